### rtl/core/tph_pkg.sv
// Shared command and status codes for the timed position history unit.
package tph_pkg;

  // Command field values.
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Status field values.
  localparam logic [2:0] ST_RECORDED = 3'd0;
  localparam logic [2:0] ST_EXACT    = 3'd1;
  localparam logic [2:0] ST_INTERP   = 3'd2;
  localparam logic [2:0] ST_EARLY    = 3'd3;
  localparam logic [2:0] ST_LATE     = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;

  // Fraction width of the interpolation weight.
  localparam int unsigned FRAC_W = 16;

endpackage

### rtl/core/timed_position_history_unit.sv
// Timed position history unit: circular history memory, binary search and interpolation.
// A record word writes the newest entry into a circular memory, and its result strobes on the
// next cycle. A lookup word on a filled history runs a binary search over the stored stamps,
// with each probe going through the single registered memory read port, for up to
// floor(log2(DEPTH))+1 probes plus one read of the older neighbor, then one more read
// for the newer neighbor, a restoring divide for the fraction and one shared multiplier
// used in turn for the three axes. A lookup keeps busy_o high while it runs, and its result
// strobes on the cycle after. Entries older than the recorded samples are held in fill
// registers, so no clearing pass is needed. The result is shown for one cycle on done_o and
// cannot be stalled.
module timed_position_history_unit
  import tph_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               command_i,
  input  logic        [31:0] stamp_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] fill_x_i,
  input  logic signed [31:0] fill_y_i,
  input  logic signed [31:0] fill_z_i,
  output logic               done_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic        [2:0]  status_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = CW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic signed [IW-1:0] DEPTH_S = IW'(DEPTH);
  localparam logic signed [IW-1:0] LAST_S = IW'(DEPTH - 1);

  // State codes.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRCH = 4'd1;
  localparam logic [3:0] S_CMP  = 4'd2;
  localparam logic [3:0] S_ONE  = 4'd3;
  localparam logic [3:0] S_A    = 4'd4;
  localparam logic [3:0] S_B    = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_MUL  = 4'd7;
  localparam logic [3:0] S_ADD  = 4'd8;

  logic [3:0] state_q, state_d;
  logic filled_q;
  logic [CW-1:0] cnt_q;
  logic [AW-1:0] wp_q;

  // Fill entry that stands for every slot older than the recorded samples.
  logic [31:0] fill_t_q;
  logic signed [31:0] fill_x_q, fill_y_q, fill_z_q;

  // Lookup working registers.
  logic [31:0] query_q;
  logic signed [IW-1:0] low_q, high_q;
  logic [2:0] st_q;
  logic [31:0] ta_q;
  logic signed [31:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;
  logic [32:0] rem_q;
  logic [31:0] span_q;
  logic [FRAC_W-1:0] frac_q;
  logic [3:0] step_q;
  logic [1:0] axis_q;
  logic signed [49:0] prod_q;
  logic done_q;
  logic signed [31:0] ox_q, oy_q, oz_q;
  logic [2:0] ost_q;

  // History memory: {stamp, x, y, z} per word.
  logic [127:0] mem [DEPTH];
  logic [127:0] rdata_q;
  logic real_q;
  logic rd_en;
  logic [AW-1:0] rd_lidx;
  logic [AW:0] phys_sum;
  logic [AW-1:0] rd_addr;
  logic rd_real;
  logic wr_en;

  assign busy_o = (state_q != S_IDLE);
  wire accept = start_i && !busy_o;
  assign wr_en = accept && (command_i == CMD_RECORD);

  // Logical index 0 is the oldest; map it onto the circular memory.
  assign phys_sum = {1'b0, wp_q} + {1'b0, rd_lidx};
  assign rd_addr = (phys_sum >= (AW+1)'(DEPTH)) ? AW'(phys_sum - (AW+1)'(DEPTH))
                                                 : phys_sum[AW-1:0];
  assign rd_real = ({1'b0, rd_lidx} >= (DEPTH_C - cnt_q));

  // Memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wp_q] <= {stamp_i, pos_x_i, pos_y_i, pos_z_i};
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
      real_q  <= rd_real;
    end
  end

  // Entry fields as read, with old slots served from the fill registers.
  logic [31:0] rd_t;
  logic signed [31:0] rd_x, rd_y, rd_z;
  assign rd_t = real_q ? rdata_q[127:96] : fill_t_q;
  assign rd_x = real_q ? rdata_q[95:64]  : fill_x_q;
  assign rd_y = real_q ? rdata_q[63:32]  : fill_y_q;
  assign rd_z = real_q ? rdata_q[31:0]   : fill_z_q;

  // Search midpoint and read address selection.
  logic signed [IW-1:0] mid;
  logic signed [IW-1:0] mid_q;
  assign mid = low_q + ((high_q - low_q) >>> 1);

  always_comb begin
    rd_en   = 1'b0;
    rd_lidx = '0;
    case (state_q)
      S_SRCH: begin
        rd_en = 1'b1;
        if (low_q > high_q) begin
          if (low_q <= 0) begin
            rd_lidx = '0;
          end else if (low_q >= DEPTH_S) begin
            rd_lidx = LAST_S[AW-1:0];
          end else begin
            rd_lidx = AW'(low_q - 1);
          end
        end else begin
          rd_lidx = mid[AW-1:0];
        end
      end
      S_A: begin
        rd_en   = 1'b1;
        rd_lidx = low_q[AW-1:0];
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Divider step and shared multiplier.
  logic [32:0] rem_dbl;
  logic signed [32:0] diff;
  logic signed [31:0] sel_a, sel_b;
  logic signed [49:0] sum_res;
  assign rem_dbl = {rem_q[31:0], 1'b0};

  always_comb begin
    case (axis_q)
      2'd0: begin
        sel_a = ax_q;
        sel_b = bx_q;
      end
      2'd1: begin
        sel_a = ay_q;
        sel_b = by_q;
      end
      default: begin
        sel_a = az_q;
        sel_b = bz_q;
      end
    endcase
  end
  assign diff = 33'(sel_b) - 33'(sel_a);
  assign sum_res = 50'(sel_a) + (prod_q >>> FRAC_W);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && command_i == CMD_LOOKUP && filled_q) begin
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (low_q > high_q) begin
          state_d = ((low_q <= 0) || (low_q >= DEPTH_S)) ? S_ONE : S_A;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP:   state_d = (rd_t == query_q) ? S_IDLE : S_SRCH;
      S_ONE:   state_d = S_IDLE;
      S_A:     state_d = S_B;
      S_B: begin
        if (rd_t > ta_q && query_q > ta_q && (query_q - ta_q) < (rd_t - ta_q)) begin
          state_d = S_DIV;
        end else begin
          state_d = S_MUL;
        end
      end
      S_DIV:   state_d = (step_q == 4'd15) ? S_MUL : S_DIV;
      S_MUL:   state_d = S_ADD;
      S_ADD:   state_d = (axis_q == 2'd2) ? S_IDLE : S_MUL;
      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      filled_q <= 1'b0;
      cnt_q    <= '0;
      wp_q     <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (wr_en) begin
        filled_q <= 1'b1;
        if (cnt_q != DEPTH_C) begin
          cnt_q <= cnt_q + CW'(1);
        end
        wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
      end
      if (accept && (command_i == CMD_RECORD || !filled_q)) begin
        done_q <= 1'b1;
      end
      if ((state_q == S_CMP && rd_t == query_q) || state_q == S_ONE ||
          (state_q == S_ADD && axis_q == 2'd2)) begin
        done_q <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          query_q <= stamp_i;
          low_q   <= '0;
          high_q  <= LAST_S;
          if (command_i == CMD_RECORD) begin
            ox_q  <= '0;
            oy_q  <= '0;
            oz_q  <= '0;
            ost_q <= ST_RECORDED;
            if (!filled_q) begin
              fill_t_q <= stamp_i;
              fill_x_q <= fill_x_i;
              fill_y_q <= fill_y_i;
              fill_z_q <= fill_z_i;
            end
          end else if (!filled_q) begin
            ox_q  <= pos_x_i;
            oy_q  <= pos_y_i;
            oz_q  <= pos_z_i;
            ost_q <= ST_EMPTY;
          end
        end
      end
      S_SRCH: begin
        mid_q <= mid;
        st_q  <= (low_q <= 0) ? ST_EARLY : ST_LATE;
      end
      S_CMP: begin
        if (rd_t == query_q) begin
          ox_q  <= rd_x;
          oy_q  <= rd_y;
          oz_q  <= rd_z;
          ost_q <= ST_EXACT;
        end else if (rd_t < query_q) begin
          low_q <= mid_q + IW'(1);
        end else begin
          high_q <= mid_q - IW'(1);
        end
      end
      S_ONE: begin
        ox_q  <= rd_x;
        oy_q  <= rd_y;
        oz_q  <= rd_z;
        ost_q <= st_q;
      end
      S_A: begin
        ta_q <= rd_t;
        ax_q <= rd_x;
        ay_q <= rd_y;
        az_q <= rd_z;
      end
      S_B: begin
        bx_q   <= rd_x;
        by_q   <= rd_y;
        bz_q   <= rd_z;
        axis_q <= 2'd0;
        step_q <= '0;
        rem_q  <= {1'b0, query_q - ta_q};
        span_q <= rd_t - ta_q;
        if (rd_t > ta_q && query_q > ta_q) begin
          frac_q <= '1;
        end else begin
          frac_q <= '0;
        end
      end
      S_DIV: begin
        step_q <= step_q + 4'd1;
        if (rem_dbl >= {1'b0, span_q}) begin
          rem_q  <= rem_dbl - {1'b0, span_q};
          frac_q <= {frac_q[FRAC_W-2:0], 1'b1};
        end else begin
          rem_q  <= rem_dbl;
          frac_q <= {frac_q[FRAC_W-2:0], 1'b0};
        end
      end
      S_MUL: begin
        prod_q <= 50'(diff) * $signed({1'b0, frac_q});
      end
      S_ADD: begin
        case (axis_q)
          2'd0:    ox_q <= sum_res[31:0];
          2'd1:    oy_q <= sum_res[31:0];
          default: oz_q <= sum_res[31:0];
        endcase
        ost_q  <= ST_INTERP;
        axis_q <= axis_q + 2'd1;
      end
      default: begin
        ost_q <= ost_q;
      end
    endcase
  end

  assign done_o   = done_q;
  assign out_x_o  = ox_q;
  assign out_y_o  = oy_q;
  assign out_z_o  = oz_q;
  assign status_o = ost_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= DEPTH_C)
    else $error("sample count exceeds depth");
  a_filled_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q == (cnt_q != '0))
    else $error("filled flag disagrees with sample count");
  a_search_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> filled_q)
    else $error("lookup search on empty history");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (state_q == S_IDLE || $past(state_q) == S_IDLE))
    else $error("result strobe while lookup still running");
`endif

endmodule

### tb/timed_position_history_unit_tb.sv
// Self-checking testbench for the timed position history unit.
`timescale 1ns / 100ps

module timed_position_history_unit_tb
  import tph_pkg::*;
();

  localparam int unsigned DEPTH = 16;

  typedef struct packed {
    logic               command;
    logic        [31:0] stamp;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] fill_x;
    logic signed [31:0] fill_y;
    logic signed [31:0] fill_z;
  } cmd_word_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic        [2:0]  status;
  } pos_word_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic               command_i;
  logic        [31:0] stamp_i;
  logic signed [31:0] pos_x_i, pos_y_i, pos_z_i;
  logic signed [31:0] fill_x_i, fill_y_i, fill_z_i;
  logic               done_o;
  logic signed [31:0] out_x_o, out_y_o, out_z_o;
  logic        [2:0]  status_o;

  timed_position_history_unit #(.DEPTH(DEPTH)) u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .command_i, .stamp_i,
    .pos_x_i, .pos_y_i, .pos_z_i, .fill_x_i, .fill_y_i, .fill_z_i,
    .done_o, .out_x_o, .out_y_o, .out_z_o, .status_o
  );

  // Shadow copy of the history.
  logic        [31:0] hist_time [DEPTH];
  logic signed [31:0] hist_x [DEPTH];
  logic signed [31:0] hist_y [DEPTH];
  logic signed [31:0] hist_z [DEPTH];
  logic               hist_filled;

  cmd_word_t pending_words[$];
  pos_word_t expected_positions[$];
  int        fail_count = 0;
  logic      hold_for_drain;
  int        burst_left;
  int        gap_left;
  logic [31:0] last_stamp;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
  end
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Weighted blend a + floor((b - a) * frac / 65536), with the difference taken at 33 bits.
  function automatic logic signed [31:0] blend(logic signed [31:0] a, logic signed [31:0] b,
                                               logic [15:0] frac);
    logic signed [32:0] diff;
    logic signed [49:0] prod;
    diff = 33'(b) - 33'(a);
    prod = 50'(diff) * $signed({1'b0, frac});
    return 32'(50'(a) + (prod >>> FRAC_W));
  endfunction

  // Predicts the word produced for one command and updates the shadow history.
  function automatic pos_word_t predict_position(cmd_word_t w);
    pos_word_t r;
    int lo, hi, mid;
    logic [31:0] ta, tb, span, delta;
    logic [15:0] frac;
    logic [47:0] quot;
    r = '0;
    if (w.command == CMD_RECORD) begin
      if (!hist_filled) begin
        for (int i = 0; i < DEPTH; i++) begin
          hist_time[i] = w.stamp;
          hist_x[i] = w.fill_x;
          hist_y[i] = w.fill_y;
          hist_z[i] = w.fill_z;
        end
        hist_filled = 1'b1;
      end
      for (int i = 0; i < DEPTH - 1; i++) begin
        hist_time[i] = hist_time[i + 1];
        hist_x[i] = hist_x[i + 1];
        hist_y[i] = hist_y[i + 1];
        hist_z[i] = hist_z[i + 1];
      end
      hist_time[DEPTH - 1] = w.stamp;
      hist_x[DEPTH - 1] = w.pos_x;
      hist_y[DEPTH - 1] = w.pos_y;
      hist_z[DEPTH - 1] = w.pos_z;
      r.status = ST_RECORDED;
      return r;
    end
    if (!hist_filled) begin
      r = '{w.pos_x, w.pos_y, w.pos_z, ST_EMPTY};
      return r;
    end
    lo = 0;
    hi = DEPTH - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (hist_time[mid] == w.stamp) begin
        r = '{hist_x[mid], hist_y[mid], hist_z[mid], ST_EXACT};
        return r;
      end
      if (hist_time[mid] < w.stamp) lo = mid + 1;
      else hi = mid - 1;
    end
    if (lo <= 0) begin
      r = '{hist_x[0], hist_y[0], hist_z[0], ST_EARLY};
      return r;
    end
    if (lo >= DEPTH) begin
      r = '{hist_x[DEPTH - 1], hist_y[DEPTH - 1], hist_z[DEPTH - 1], ST_LATE};
      return r;
    end
    ta = hist_time[lo - 1];
    tb = hist_time[lo];
    frac = '0;
    if (tb > ta && w.stamp > ta) begin
      span = tb - ta;
      delta = w.stamp - ta;
      if (delta >= span) begin
        frac = 16'hFFFF;
      end else begin
        quot = {delta, 16'h0} / 48'(span);
        frac = (quot > 48'hFFFF) ? 16'hFFFF : quot[15:0];
      end
    end
    r.x = blend(hist_x[lo - 1], hist_x[lo], frac);
    r.y = blend(hist_y[lo - 1], hist_y[lo], frac);
    r.z = blend(hist_z[lo - 1], hist_z[lo], frac);
    r.status = ST_INTERP;
    return r;
  endfunction

  function automatic cmd_word_t rand_word(logic cmd, logic [31:0] stamp);
    cmd_word_t w;
    w.command = cmd;
    w.stamp = stamp;
    w.pos_x = $urandom;
    w.pos_y = $urandom;
    w.pos_z = $urandom;
    w.fill_x = $urandom;
    w.fill_y = $urandom;
    w.fill_z = $urandom;
    return w;
  endfunction

  // Query stamp near the stored span: exact hits, neighbors and outliers.
  function automatic logic [31:0] pick_query();
    int k;
    k = $urandom_range(0, DEPTH - 1);
    case ($urandom_range(0, 5))
      0: return hist_time[k];
      1: return hist_time[k] + 32'd1;
      2: return hist_time[k] - 32'd1;
      3: return hist_time[k] + $urandom_range(0, 5000);
      4: return $urandom;
      default: return hist_time[0] + 32'($urandom_range(0, 32'(hist_time[DEPTH - 1]
                 - hist_time[0]) & 32'h00FF_FFFF));
    endcase
  endfunction

  // Driver: bursts and gaps, with an optional hold until the pipeline drains.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      command_i <= CMD_RECORD;
      stamp_i <= '0;
      {pos_x_i, pos_y_i, pos_z_i, fill_x_i, fill_y_i, fill_z_i} <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (!(start_i && busy_o)) begin
        if (hold_for_drain && expected_positions.size() != 0) begin
          start_i <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start_i <= 1'b0;
        end else if (pending_words.size() != 0) begin
          cmd_word_t w;
          w = pending_words.pop_front();
          expected_positions.push_back(predict_position(w));
          {command_i, stamp_i, pos_x_i, pos_y_i, pos_z_i, fill_x_i, fill_y_i, fill_z_i} <= w;
          start_i <= 1'b1;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares every result word against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_positions.size() == 0) begin
        $error("unexpected result word: status %0d", status_o);
        fail_count = fail_count + 1;
      end else begin
        pos_word_t e;
        e = expected_positions.pop_front();
        if (out_x_o !== e.x) begin
          $error("out_x expected %h actual %h", e.x, out_x_o);
          fail_count = fail_count + 1;
        end
        if (out_y_o !== e.y) begin
          $error("out_y expected %h actual %h", e.y, out_y_o);
          fail_count = fail_count + 1;
        end
        if (out_z_o !== e.z) begin
          $error("out_z expected %h actual %h", e.z, out_z_o);
          fail_count = fail_count + 1;
        end
        if (status_o !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status_o);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int n;
    cmd_word_t w;
    hist_filled = 1'b0;
    hold_for_drain = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      hist_time[i] = '0;
      hist_x[i] = '0;
      hist_y[i] = '0;
      hist_z[i] = '0;
    end
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-history lookups with extreme fallbacks.
    w = rand_word(CMD_LOOKUP, 32'h0);
    w.pos_x = 32'sh7FFF_FFFF; w.pos_y = 32'sh8000_0000; w.pos_z = '0;
    pending_words.push_back(w);
    w = rand_word(CMD_LOOKUP, 32'hFFFF_FFFF);
    w.pos_x = 32'sh8000_0000; w.pos_y = 32'sh7FFF_FFFF; w.pos_z = -1;
    pending_words.push_back(w);
    // First record fills with extreme values, then samples with repeated stamps.
    w = rand_word(CMD_RECORD, 32'd1000);
    w.fill_x = 32'sh8000_0000; w.fill_y = 32'sh7FFF_FFFF; w.fill_z = -1;
    w.pos_x = 32'sh7FFF_FFFF; w.pos_y = 32'sh8000_0000; w.pos_z = 0;
    pending_words.push_back(w);
    pending_words.push_back(rand_word(CMD_RECORD, 32'd1000));
    pending_words.push_back(rand_word(CMD_RECORD, 32'd2000));
    pending_words.push_back(rand_word(CMD_RECORD, 32'hFFFF_FFFF));
    pending_words.push_back(rand_word(CMD_LOOKUP, 32'd0));
    pending_words.push_back(rand_word(CMD_LOOKUP, 32'd1000));
    pending_words.push_back(rand_word(CMD_LOOKUP, 32'd1500));
    pending_words.push_back(rand_word(CMD_LOOKUP, 32'd2001));
    pending_words.push_back(rand_word(CMD_LOOKUP, 32'hFFFF_FFFE));
    pending_words.push_back(rand_word(CMD_LOOKUP, 32'hFFFF_FFFF));
    // Out-of-order stamps give a negative span.
    pending_words.push_back(rand_word(CMD_RECORD, 32'd5));
    pending_words.push_back(rand_word(CMD_LOOKUP, 32'd3000));
    pending_words.push_back(rand_word(CMD_LOOKUP, 32'd999));

    // Pause until every expected word has come.
    wait (pending_words.size() == 0 && expected_positions.size() == 0);
    hold_for_drain = 1'b1;
    @(posedge clk_i);

    // Random: mostly rising-stamp records and lookups around the stored span.
    n = 0;
    last_stamp = $urandom_range(0, 1000);
    while (n < 1500) begin
      if (pending_words.size() > 4) begin
        @(posedge clk_i);
        continue;
      end
      if (n == 700) begin
        wait (pending_words.size() == 0 && expected_positions.size() == 0);
      end
      hold_for_drain = (n >= 700 && n < 720);
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0: last_stamp = $urandom;
          1: last_stamp = last_stamp;
          default: last_stamp = last_stamp + $urandom_range(1, 3000);
        endcase
        pending_words.push_back(rand_word(CMD_RECORD, last_stamp));
      end else begin
        // Predict-time history is what the query is picked against; close enough.
        pending_words.push_back(rand_word(CMD_LOOKUP, pick_query()));
      end
      n++;
    end
    wait (pending_words.size() == 0 && expected_positions.size() == 0);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0 && expected_positions.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule

### timed_position_history_unit.f
rtl/core/tph_pkg.sv
rtl/core/timed_position_history_unit.sv
tb/timed_position_history_unit_tb.sv
